// ----- hw/rtl/ohr_pkg.sv -----
`default_nettype none

package ohr_pkg;

  localparam int OP_SLOTS        = 256;
  localparam int OP_W            = 8;
  localparam int RANK_W          = 5;
  localparam int DIST_W          = 9;
  localparam int OUT_CNT_W       = 32;
  localparam int TOP_LIMIT_DEF   = 20;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_REPORT = 1'b1
  } req_kind_t;

  // one counted opcode entering the counter store
  typedef struct packed {
    logic            en;
    logic [OP_W-1:0] op;
  } tick_t;

  // sweep read of the counter store during a report
  typedef struct packed {
    logic            en;
    logic [OP_W-1:0] addr;
  } cnt_rd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ohr_req_if.sv -----
`default_nettype none

interface ohr_req_if
  import ohr_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [OP_W-1:0] opcode;

  modport source (output valid, output req_type, output opcode, input ready);
  modport sink (input valid, input req_type, input opcode, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ohr_res_if.sv -----
`default_nettype none

interface ohr_res_if
  import ohr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RANK_W-1:0]    rank;
  logic [OP_W-1:0]      ranked_opcode;
  logic [OUT_CNT_W-1:0] opcode_count;
  logic [OUT_CNT_W-1:0] total_count;
  logic [DIST_W-1:0]    distinct_ops;
  logic                 last;

  modport source (output valid, output rank, output ranked_opcode, output opcode_count,
                  output total_count, output distinct_ops, output last, input ready);
  modport sink (input valid, input rank, input ranked_opcode, input opcode_count,
                input total_count, input distinct_ops, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/opcode_histogram_top_rank.sv -----
`default_nettype none

// Opcode histogram with a ranked top list. Tick requests (req_type 0) are taken one per
// cycle while no report runs; each adds one, saturating, to its opcode's counter and to
// the grand total, through a read-modify-write of the counter memory with forwarding
// between back-to-back ticks, and gives no result. A report request (req_type 1) gives
// nothing if the total is zero; otherwise it holds off further requests while it copies
// all 256 counters into the order memory, one counter memory read per cycle, and then
// runs one selection pass per emitted rank, pass k scanning positions k..255 of the order
// memory at one entry per cycle through that memory's single read port. A report gives
// n ranks, n = min(distinct, TOP_LIMIT), and each rank waits for the output to be free.
// Counters are not cleared by a report.
module opcode_histogram_top_rank
  import ohr_pkg::*;
#(
  parameter int TOP_LIMIT   = TOP_LIMIT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  ohr_req_if.sink    req,
  ohr_res_if.source  res
);

  tick_t                  tick;
  cnt_rd_t                sweep;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [COUNT_WIDTH-1:0] total;
  logic                   accept;
  logic                   start;
  logic                   idle;

  assign req.ready = idle;
  assign accept    = req.valid && req.ready;
  assign tick.en   = accept && (req_kind_t'(req.req_type) == REQ_TICK);
  assign tick.op   = req.opcode;
  assign start     = accept && (req_kind_t'(req.req_type) == REQ_REPORT) && (total != '0);

  ohr_cnt_store #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cnt (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .sweep  (sweep),
    .rd_cnt (rd_cnt),
    .total  (total)
  );

  ohr_rank_sort #(
    .TOP_LIMIT   (TOP_LIMIT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sort (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .idle   (idle),
    .sweep  (sweep),
    .rd_cnt (rd_cnt),
    .total  (total),
    .res    (res)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ohr_cnt_store.sv -----
`default_nettype none

module ohr_cnt_store
  import ohr_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  tick_t                   tick,
  input  cnt_rd_t                 sweep,
  output logic [COUNT_WIDTH-1:0]  rd_cnt,
  output logic [COUNT_WIDTH-1:0]  total
);

  logic [COUNT_WIDTH-1:0] mem [OP_SLOTS];
  logic [OP_SLOTS-1:0]    written;
  logic [OP_W-1:0]        rd_addr;
  logic                   rd_en;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_vld;
  logic                   p_valid;
  logic [OP_W-1:0]        p_op;
  logic                   w_valid;
  logic [OP_W-1:0]        w_op;
  logic [COUNT_WIDTH-1:0] w_data;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;

  assign rd_en   = tick.en || sweep.en;
  assign rd_addr = sweep.en ? sweep.addr : tick.op;
  assign rd_cnt  = rd_vld ? rd_q : '0;

  // forward the write that landed on the same edge as this read
  assign cur = (w_valid && (w_op == p_op)) ? w_data : rd_cnt;
  assign inc = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (p_valid) begin
      mem[p_op] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
      p_valid <= 1'b0;
      w_valid <= 1'b0;
      total   <= '0;
    end else begin
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
      if (p_valid) begin
        written[p_op] <= 1'b1;
      end
      p_valid <= tick.en;
      w_valid <= p_valid;
      if (tick.en && (total != '1)) begin
        total <= total + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_op   <= tick.op;
    w_op   <= p_op;
    w_data <= inc;
  end

`ifndef SYNTHESIS
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    tick.en |-> !sweep.en)
    else $error("tick and sweep read collide on the counter port");

  a_total_holds_max: assert property (@(posedge clk) disable iff (rst)
    (total == '1) |=> (total == '1))
    else $error("grand total wrapped past its maximum");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    p_valid |=> w_valid)
    else $error("counter update lost in the write stage");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ohr_rank_sort.sv -----
`default_nettype none

module ohr_rank_sort
  import ohr_pkg::*;
#(
  parameter int TOP_LIMIT   = TOP_LIMIT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  logic                    start,
  output logic                    idle,
  output cnt_rd_t                 sweep,
  input  logic [COUNT_WIDTH-1:0]  rd_cnt,
  input  logic [COUNT_WIDTH-1:0]  total,
  ohr_res_if.source               res
);

  localparam int ENT_W = OP_W + COUNT_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_SWAP
  } state_t;

  state_t                 state;
  logic [ENT_W-1:0]       ord_mem [OP_SLOTS];
  logic                   ord_we;
  logic [OP_W-1:0]        ord_wa;
  logic [ENT_W-1:0]       ord_wd;
  logic [ENT_W-1:0]       ord_q;
  logic [OP_W-1:0]        q_op;
  logic [COUNT_WIDTH-1:0] q_cnt;

  logic                   ld_iss;
  logic [OP_W-1:0]        ld_addr;
  logic                   ld_dv;
  logic [OP_W-1:0]        ld_addr_d;
  logic [DIST_W-1:0]      seen;
  logic [DIST_W-1:0]      seen_next;
  logic [DIST_W-1:0]      top;

  logic [OP_W-1:0]        pass_i;
  logic                   sc_iss;
  logic [OP_W-1:0]        sc_addr;
  logic                   sc_dv;
  logic [OP_W-1:0]        sc_pos;
  logic [OP_W-1:0]        cur_op;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [OP_W-1:0]        best_op;
  logic [COUNT_WIDTH-1:0] best_cnt;
  logic [OP_W-1:0]        best_pos;
  logic                   pass_last;
  logic                   out_free;

  assign idle       = (state == S_IDLE);
  assign sweep.en   = (state == S_LOAD) && ld_iss;
  assign sweep.addr = ld_addr;

  assign q_op      = ord_q[ENT_W-1 -: OP_W];
  assign q_cnt     = ord_q[COUNT_WIDTH-1:0];
  assign seen_next = seen + DIST_W'(rd_cnt != '0);
  assign pass_last = (({1'b0, pass_i} + DIST_W'(1)) == top);
  assign out_free  = !res.valid || res.ready;

  always_comb begin
    ord_we = 1'b0;
    ord_wa = best_pos;
    ord_wd = {cur_op, cur_cnt};
    if (state == S_LOAD) begin
      ord_we = ld_dv;
      ord_wa = ld_addr_d;
      ord_wd = {ld_addr_d, rd_cnt};
    end else if (state == S_SWAP) begin
      ord_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && sc_iss) begin
      ord_q <= ord_mem[sc_addr];
    end
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ld_iss    <= 1'b0;
      ld_dv     <= 1'b0;
      sc_iss    <= 1'b0;
      sc_dv     <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      ld_dv     <= ld_iss && (state == S_LOAD);
      ld_addr_d <= ld_addr;
      sc_dv     <= sc_iss && (state == S_SCAN);
      sc_pos    <= sc_addr;
      if (res.ready && !((state == S_SWAP) && out_free)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state   <= S_LOAD;
            ld_iss  <= 1'b1;
            ld_addr <= '0;
            seen    <= '0;
          end
        end
        S_LOAD: begin
          if (ld_iss) begin
            if (ld_addr == '1) begin
              ld_iss <= 1'b0;
            end else begin
              ld_addr <= ld_addr + OP_W'(1);
            end
          end
          if (ld_dv) begin
            seen <= seen_next;
            if (ld_addr_d == '1) begin
              top     <= (seen_next < DIST_W'(TOP_LIMIT)) ? seen_next : DIST_W'(TOP_LIMIT);
              state   <= S_SCAN;
              pass_i  <= '0;
              sc_addr <= '0;
              sc_iss  <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (sc_iss) begin
            if (sc_addr == '1) begin
              sc_iss <= 1'b0;
            end else begin
              sc_addr <= sc_addr + OP_W'(1);
            end
          end
          if (sc_dv) begin
            if (sc_pos == pass_i) begin
              cur_op   <= q_op;
              cur_cnt  <= q_cnt;
              best_op  <= q_op;
              best_cnt <= q_cnt;
              best_pos <= sc_pos;
            end else if (q_cnt > best_cnt) begin
              best_op  <= q_op;
              best_cnt <= q_cnt;
              best_pos <= sc_pos;
            end
            if (sc_pos == '1) begin
              state <= S_SWAP;
            end
          end
        end
        S_SWAP: begin
          if (out_free) begin
            res.valid         <= 1'b1;
            res.rank          <= RANK_W'({1'b0, pass_i} + DIST_W'(1));
            res.ranked_opcode <= best_op;
            res.opcode_count  <= OUT_CNT_W'(best_cnt);
            res.total_count   <= OUT_CNT_W'(total);
            res.distinct_ops  <= seen;
            res.last          <= pass_last;
            if (pass_last) begin
              state <= S_IDLE;
            end else begin
              state   <= S_SCAN;
              pass_i  <= pass_i + OP_W'(1);
              sc_addr <= pass_i + OP_W'(1);
              sc_iss  <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pass_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, pass_i} < top))
    else $error("sort pass beyond report length");

  a_result_has_entries: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.distinct_ops != '0))
    else $error("result issued from an empty histogram");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("report request taken while a report runs");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_opcode_histogram_top_rank.sv -----
`timescale 1ns / 100ps

module tb_opcode_histogram_top_rank;
  import ohr_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int TOP_LIMIT      = TOP_LIMIT_DEF;
  localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 180;
  localparam int MIN_ENTRIES    = 48;
  localparam int HOT_POOL       = 24;
  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE_CYCLES  = 600;
  localparam int TIMEOUT_CYCLES = 4_000_000;
  localparam int MAX_REPORTS    = 40;

  localparam bit [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef struct {
    bit [RANK_W-1:0]    rank;
    bit [OP_W-1:0]      opcode;
    bit [OUT_CNT_W-1:0] count;
    bit [OUT_CNT_W-1:0] total;
    bit [DIST_W-1:0]    distinct;
    bit                 last;
  } rank_entry_t;

  class opcode_tally;
    bit [COUNT_WIDTH-1:0] counts[OP_SLOTS];
    bit [COUNT_WIDTH-1:0] total;
    rank_entry_t          ranked_due[$];
    int                   errors;
    int                   requests;
    int                   reports;
    int                   made;
    int                   checked;
    int                   peak_distinct;

    function void note_request(req_kind_t kind, bit [OP_W-1:0] op);
      requests++;
      if (kind == REQ_TICK) begin
        if (counts[op] != CNT_MAX) counts[op]++;
        if (total != CNT_MAX) total++;
      end else begin
        reports++;
        if (total != 0) rank_top_list();
      end
    endfunction

    // passes beyond the emitted places never move the first ones
    function void rank_top_list();
      bit [OP_W-1:0] order[OP_SLOTS];
      bit [OP_W-1:0] swap;
      rank_entry_t   e;
      int            seen;
      int            top;
      int            best;
      seen = 0;
      for (int i = 0; i < OP_SLOTS; i++) begin
        order[i] = OP_W'(i);
        if (counts[i] != 0) seen++;
      end
      top = (seen < TOP_LIMIT) ? seen : TOP_LIMIT;
      for (int i = 0; i < top; i++) begin
        best = i;
        for (int j = i + 1; j < OP_SLOTS; j++)
          if (counts[order[j]] > counts[order[best]]) best = j;
        if (best != i) begin
          swap        = order[i];
          order[i]    = order[best];
          order[best] = swap;
        end
      end
      if (seen > peak_distinct) peak_distinct = seen;
      for (int i = 0; i < top; i++) begin
        e.rank     = RANK_W'(i + 1);
        e.opcode   = order[i];
        e.count    = OUT_CNT_W'(counts[order[i]]);
        e.total    = OUT_CNT_W'(total);
        e.distinct = DIST_W'(seen);
        e.last     = (i + 1 == top);
        ranked_due.push_back(e);
        made++;
      end
    endfunction

    function void flag(string what, int rank, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch at rank %0d: expected %0d, actual %0d",
                   $time, what, rank, want, got);
      end
    endfunction

    function void check_entry(rank_entry_t got);
      rank_entry_t want;
      if (ranked_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unrequested entry: expected none, actual rank %0d opcode %0d",
                   $time, got.rank, got.opcode);
        return;
      end
      want = ranked_due.pop_front();
      checked++;
      flag("rank", want.rank, want.rank, got.rank);
      flag("ranked_opcode", want.rank, want.opcode, got.opcode);
      flag("opcode_count", want.rank, want.count, got.count);
      flag("total_count", want.rank, want.total, got.total);
      flag("distinct_ops", want.rank, want.distinct, got.distinct);
      flag("last", want.rank, want.last, got.last);
    endfunction

    function int pending();
      return ranked_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   long_hold_req;
  int   long_hold_done;

  ohr_req_if req_ch ();
  ohr_res_if res_ch ();

  opcode_tally tally = new;

  opcode_histogram_top_rank DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .res (res_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d entries outstanding", tally.pending());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    rank_entry_t got;
    if (!rst) begin
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        tally.note_request(req_kind_t'(req_ch.req_type), req_ch.opcode);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.rank     = res_ch.rank;
        got.opcode   = res_ch.ranked_opcode;
        got.count    = res_ch.opcode_count;
        got.total    = res_ch.total_count;
        got.distinct = res_ch.distinct_ops;
        got.last     = res_ch.last;
        tally.check_entry(got);
      end
    end
  end

  // result side back-pressure
  initial begin
    int mode;
    int left;
    int phase;
    mode  = 0;
    left  = 0;
    phase = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req != long_hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        phase++;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= (phase % 4 == 0);
          default: res_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_req(input req_kind_t kind, input bit [OP_W-1:0] op);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.opcode   <= op;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic idle_req(input int cycles);
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_W'($urandom_range(0, 255));
    repeat (cycles) @(negedge clk);
  endtask

  task automatic await_drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (tally.pending() != 0);
  endtask

  initial begin
    bit [OP_W-1:0] hot_ops[HOT_POOL];
    int            sent;
    int            len;
    int            pick;
    bit            pressed;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.opcode   = '0;
    long_hold_req   = 0;
    long_hold_done  = 0;
    rst             = 1'b1;
    sent            = 0;
    pressed         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send_req(REQ_REPORT, 8'h3C);
    send_req(REQ_TICK, 8'h00);
    send_req(REQ_TICK, 8'hFF);
    idle_req(2);
    send_req(REQ_TICK, 8'hFF);
    send_req(REQ_TICK, 8'h55);
    send_req(REQ_TICK, 8'hAA);
    send_req(REQ_TICK, 8'hAA);
    send_req(REQ_TICK, 8'hAA);
    send_req(REQ_REPORT, 8'hFF);
    send_req(REQ_TICK, 8'h55);
    send_req(REQ_TICK, 8'h00);
    send_req(REQ_TICK, 8'h01);
    idle_req(1);
    send_req(REQ_TICK, 8'h80);
    send_req(REQ_TICK, 8'h7F);
    send_req(REQ_REPORT, 8'h00);
    send_req(REQ_REPORT, 8'hA5);
    await_drain();

    for (int i = 0; i < HOT_POOL; i++) hot_ops[i] = OP_W'($urandom_range(0, 255));
    hot_ops[0] = 8'h00;
    hot_ops[1] = 8'hFF;

    while ((sent < RANDOM_ITEMS || tally.made < MIN_ENTRIES) && tally.reports < MAX_REPORTS)
    begin
      len = $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        if (!pressed && sent >= RANDOM_ITEMS / 2) begin
          pressed = 1'b1;
          long_hold_req++;
          send_req(REQ_REPORT, OP_W'($urandom_range(0, 255)));
          for (int m = 0; m < 12; m++) send_req(REQ_TICK, hot_ops[$urandom_range(0, 3)]);
          sent += 13;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5 || (sent >= RANDOM_ITEMS && tally.made < MIN_ENTRIES && pick < 30))
          send_req(REQ_REPORT, OP_W'($urandom_range(0, 255)));
        else if (pick < 25)
          send_req(REQ_TICK, OP_W'($urandom_range(0, 255)));
        else
          send_req(REQ_TICK, hot_ops[$urandom_range(0, HOT_POOL - 1)]);
        sent++;
      end
      pick = $urandom_range(0, 15);
      if (pick == 0)
        await_drain();
      else if (pick > 4)
        idle_req($urandom_range(1, 8));
    end

    await_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d requests including %0d reports; %0d ranked entries compared",
             tally.requests, tally.reports, tally.checked);
    $display("widest report saw %0d distinct opcodes, %0d still outstanding",
             tally.peak_distinct, tally.pending());
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- opcode_histogram_top_rank.f -----
hw/rtl/ohr_pkg.sv
hw/rtl/ohr_req_if.sv
hw/rtl/ohr_res_if.sv
hw/rtl/ohr_cnt_store.sv
hw/rtl/ohr_rank_sort.sv
hw/rtl/opcode_histogram_top_rank.sv
bench/tb_opcode_histogram_top_rank.sv
